@@ rtl/tmca_pkg.sv @@
// Shared constants, types and codes for the tile memory compacting allocator.
`default_nettype none
package tmca_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int TOTAL_CHARS = 2048;

  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int PASS_W = $clog2(MAX_ENTRIES + 2);
  localparam int OFF_W  = 11;
  localparam int KEY_W  = 32;
  localparam int USE_W  = 8;
  localparam int END_W  = 12;

  localparam logic [1:0] OP_ACQUIRE = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_DEFRAG  = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOTHING  = 3'd1;
  localparam logic [2:0] ST_NO_SPACE = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_BAD_SIZE = 3'd4;

  localparam logic [USE_W-1:0] USE_MAX = '1;

  typedef enum logic [4:0] {
    S_IDLE, S_LK_ORD, S_LK_SLOT, S_LK_CMP, S_AL_CHK, S_AL_SCAN,
    S_REL_RD, S_REL_CHK, S_RF_ORD, S_RF_CMP, S_SH_RD, S_SH_WR, S_REL_DONE,
    S_DF_ORD, S_DF_SLOT, S_DF_CMP, S_DF_NEXT,
    S_END, S_END_ORD, S_END_SLOT, S_END_CALC, S_OUT
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0] slot_raddr;
    logic [IDX_W-1:0] ord_raddr;
    logic             ent_we;
    logic             off_we;
    logic             use_we;
    logic [IDX_W-1:0] slot_waddr;
    logic [KEY_W-1:0] w_key;
    logic             w_shared;
    logic [OFF_W-1:0] w_off;
    logic [OFF_W-1:0] w_len;
    logic [USE_W-1:0] w_use;
    logic             ord_we;
    logic [IDX_W-1:0] ord_waddr;
    logic [IDX_W-1:0] ord_wdata;
  } table_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] ord_q;
    logic [KEY_W-1:0] key_q;
    logic             shared_q;
    logic [OFF_W-1:0] off_q;
    logic [OFF_W-1:0] len_q;
    logic [USE_W-1:0] use_q;
  } table_rsp_t;

endpackage
`default_nettype wire

@@ rtl/tmca_table.sv @@
// Entry and order memories with registered reads.
`default_nettype none
module tmca_table (
  input  wire                      clk,
  input  wire tmca_pkg::table_req_t req,
  output tmca_pkg::table_rsp_t     rsp
);
  import tmca_pkg::*;

  logic [KEY_W-1:0] key_mem    [MAX_ENTRIES];
  logic             shared_mem [MAX_ENTRIES];
  logic [OFF_W-1:0] off_mem    [MAX_ENTRIES];
  logic [OFF_W-1:0] len_mem    [MAX_ENTRIES];
  logic [USE_W-1:0] use_mem    [MAX_ENTRIES];
  logic [IDX_W-1:0] ord_mem    [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (req.ent_we) begin
      key_mem[req.slot_waddr]    <= req.w_key;
      shared_mem[req.slot_waddr] <= req.w_shared;
      len_mem[req.slot_waddr]    <= req.w_len;
    end
    if (req.ent_we || req.off_we) begin
      off_mem[req.slot_waddr] <= req.w_off;
    end
    if (req.ent_we || req.use_we) begin
      use_mem[req.slot_waddr] <= req.w_use;
    end
    if (req.ord_we) begin
      ord_mem[req.ord_waddr] <= req.ord_wdata;
    end
    rsp.key_q    <= key_mem[req.slot_raddr];
    rsp.shared_q <= shared_mem[req.slot_raddr];
    rsp.off_q    <= off_mem[req.slot_raddr];
    rsp.len_q    <= len_mem[req.slot_raddr];
    rsp.use_q    <= use_mem[req.slot_raddr];
    rsp.ord_q    <= ord_mem[req.ord_raddr];
  end

endmodule
`default_nettype wire

@@ rtl/tile_memory_compacting_allocator.sv @@
// Tile memory compacting allocator: one request word in, one result word out.
// Requests enter on in_valid/in_stall; in_stall is high from acceptance until
// the result word has been taken. Results leave on out_valid/out_stall and
// are held unchanged while out_stall is high.
// A small sequencer walks the ordered entry list through memories that each
// have one write port and one registered read port.
// Steps of each request, with N live entries:
//   clear: empties the list as the request is accepted.
//   acquire: for a shared request a lookup over the N entries; on a miss,
//     a scan for a free slot.
//   release: a position search and list shift once the use count reaches zero.
//   defragment: deferred runs one pass, otherwise up to
//     65 passes.
// Every request ends by re-reading the last entry to refresh used_chars; an empty list sets it to zero.
// A new request is taken only after the last result word has left; nothing overlaps.
// Reset empties the table at once (valid bits cleared, freed mark at one);
// no clearing pass is needed.
`default_nettype none
module tile_memory_compacting_allocator (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  opcode,
  input  wire  [31:0] tile_source_id,
  input  wire         is_shared,
  input  wire  [10:0] num_chars,
  input  wire  [5:0]  entry_id,
  input  wire         deferred,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [2:0]  status,
  output logic [5:0]  result_entry,
  output logic [10:0] result_offset,
  output logic        was_released,
  output logic [11:0] used_chars,
  output logic [11:0] free_chars,
  output logic [6:0]  entry_count,
  output logic        gap_pending
);
  import tmca_pkg::*;

  state_t state, state_next;
  logic [KEY_W-1:0] key, key_next;
  logic shr, shr_next;
  logic [OFF_W-1:0] nch, nch_next;
  logic [5:0] eid, eid_next;
  logic dfr, dfr_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [IDX_W-1:0] ent, ent_next;
  logic [PASS_W-1:0] passes, passes_next;
  logic [CNT_W-1:0] live, live_next;
  logic [END_W-1:0] freed, freed_next;
  logic [END_W-1:0] used, used_next;
  logic [OFF_W-1:0] aoff, aoff_next;
  logic rfound, rfound_next;
  logic [MAX_ENTRIES-1:0] valid, valid_next;
  logic [2:0] res_status, res_status_next;
  logic [5:0] res_entry, res_entry_next;
  logic [OFF_W-1:0] res_off, res_off_next;
  logic res_rel, res_rel_next;

  table_req_t req;
  table_rsp_t rsp;

  logic [END_W-1:0] alloc_off;
  logic [END_W:0]   alloc_sum;
  logic [USE_W-1:0] use_dec;

  tmca_table u_table (
    .clk(clk),
    .req(req),
    .rsp(rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      live   <= '0;
      freed  <= END_W'(1);
      used   <= '0;
      valid  <= '0;
    end else begin
      state  <= state_next;
      live   <= live_next;
      freed  <= freed_next;
      used   <= used_next;
      valid  <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    key        <= key_next;
    shr        <= shr_next;
    nch        <= nch_next;
    eid        <= eid_next;
    dfr        <= dfr_next;
    idx        <= idx_next;
    ent        <= ent_next;
    passes     <= passes_next;
    aoff       <= aoff_next;
    rfound     <= rfound_next;
    res_status <= res_status_next;
    res_entry  <= res_entry_next;
    res_off    <= res_off_next;
    res_rel    <= res_rel_next;
  end

  assign alloc_off = (live == '0) ? END_W'(1) : used;
  assign alloc_sum = {1'b0, alloc_off} + (END_W + 1)'(nch);
  assign use_dec   = (rsp.use_q != '0) ? rsp.use_q - USE_W'(1) : rsp.use_q;

  always_comb begin
    state_next      = state;
    key_next        = key;
    shr_next        = shr;
    nch_next        = nch;
    eid_next        = eid;
    dfr_next        = dfr;
    idx_next        = idx;
    ent_next        = ent;
    passes_next     = passes;
    live_next       = live;
    freed_next      = freed;
    used_next       = used;
    aoff_next       = aoff;
    rfound_next     = rfound;
    valid_next      = valid;
    res_status_next = res_status;
    res_entry_next  = res_entry;
    res_off_next    = res_off;
    res_rel_next    = res_rel;
    req             = '0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          key_next        = tile_source_id;
          shr_next        = is_shared;
          nch_next        = num_chars;
          eid_next        = entry_id;
          dfr_next        = deferred;
          idx_next        = '0;
          res_status_next = ST_OK;
          res_entry_next  = '0;
          res_off_next    = '0;
          res_rel_next    = 1'b0;
          unique case (opcode)
            OP_ACQUIRE: state_next = is_shared ? S_LK_ORD : S_AL_CHK;
            OP_RELEASE: begin
              if (32'(entry_id) >= 32'(MAX_ENTRIES) || !valid[entry_id[IDX_W-1:0]]) begin
                res_status_next = ST_NOTHING;
                state_next      = S_END;
              end else begin
                state_next = S_REL_RD;
              end
            end
            OP_DEFRAG: begin
              if (freed > END_W'(1)) begin
                passes_next = '0;
                state_next  = S_DF_ORD;
              end else begin
                res_status_next = ST_NOTHING;
                state_next      = S_END;
              end
            end
            OP_CLEAR: begin
              valid_next = '0;
              live_next  = '0;
              freed_next = END_W'(1);
              state_next = S_END;
            end
            default: state_next = S_END;
          endcase
        end
      end

      S_LK_ORD: begin
        if (idx >= live) begin
          state_next = S_AL_CHK;
        end else begin
          req.ord_raddr = idx[IDX_W-1:0];
          state_next    = S_LK_SLOT;
        end
      end
      S_LK_SLOT: begin
        req.slot_raddr = rsp.ord_q;
        ent_next       = rsp.ord_q;
        state_next     = S_LK_CMP;
      end
      S_LK_CMP: begin
        if (rsp.key_q == key && rsp.shared_q) begin
          req.use_we      = 1'b1;
          req.slot_waddr  = ent;
          req.w_use       = (rsp.use_q == USE_MAX) ? USE_MAX : rsp.use_q + USE_W'(1);
          res_entry_next  = 6'(ent);
          res_off_next    = rsp.off_q;
          state_next      = S_END;
        end else begin
          idx_next   = idx + CNT_W'(1);
          state_next = S_LK_ORD;
        end
      end

      S_AL_CHK: begin
        aoff_next = alloc_off[OFF_W-1:0];
        if (nch == '0 || 32'(nch) >= 32'(TOTAL_CHARS)) begin
          res_status_next = ST_BAD_SIZE;
          state_next      = S_END;
        end else if (32'(live) >= 32'(MAX_ENTRIES)) begin
          res_status_next = ST_FULL;
          state_next      = S_END;
        end else if (32'(alloc_sum) >= 32'(TOTAL_CHARS)) begin
          res_status_next = ST_NO_SPACE;
          state_next      = S_END;
        end else begin
          idx_next   = '0;
          state_next = S_AL_SCAN;
        end
      end
      S_AL_SCAN: begin
        if (32'(idx) >= 32'(MAX_ENTRIES)) begin
          res_status_next = ST_FULL;
          state_next      = S_END;
        end else if (!valid[idx[IDX_W-1:0]]) begin
          req.ent_we     = 1'b1;
          req.slot_waddr = idx[IDX_W-1:0];
          req.w_key      = key;
          req.w_shared   = shr;
          req.w_off      = aoff;
          req.w_len      = nch;
          req.w_use      = USE_W'(1);
          req.ord_we     = 1'b1;
          req.ord_waddr  = live[IDX_W-1:0];
          req.ord_wdata  = idx[IDX_W-1:0];
          valid_next[idx[IDX_W-1:0]] = 1'b1;
          live_next      = live + CNT_W'(1);
          res_entry_next = 6'(idx[IDX_W-1:0]);
          res_off_next   = aoff;
          state_next     = S_END;
        end else begin
          idx_next = idx + CNT_W'(1);
        end
      end

      S_REL_RD: begin
        req.slot_raddr = eid[IDX_W-1:0];
        state_next     = S_REL_CHK;
      end
      S_REL_CHK: begin
        req.use_we     = 1'b1;
        req.slot_waddr = eid[IDX_W-1:0];
        req.w_use      = use_dec;
        if (use_dec == '0) begin
          aoff_next  = rsp.off_q;
          idx_next   = '0;
          state_next = S_RF_ORD;
        end else begin
          state_next = S_END;
        end
      end
      S_RF_ORD: begin
        if (idx >= live) begin
          rfound_next = 1'b0;
          state_next  = S_REL_DONE;
        end else begin
          req.ord_raddr = idx[IDX_W-1:0];
          state_next    = S_RF_CMP;
        end
      end
      S_RF_CMP: begin
        if (rsp.ord_q == eid[IDX_W-1:0]) begin
          rfound_next = 1'b1;
          state_next  = S_SH_RD;
        end else begin
          idx_next   = idx + CNT_W'(1);
          state_next = S_RF_ORD;
        end
      end
      S_SH_RD: begin
        if ((idx + CNT_W'(1)) >= live) begin
          state_next = S_REL_DONE;
        end else begin
          req.ord_raddr = idx[IDX_W-1:0] + IDX_W'(1);
          state_next    = S_SH_WR;
        end
      end
      S_SH_WR: begin
        req.ord_we    = 1'b1;
        req.ord_waddr = idx[IDX_W-1:0];
        req.ord_wdata = rsp.ord_q;
        idx_next      = idx + CNT_W'(1);
        state_next    = S_SH_RD;
      end
      S_REL_DONE: begin
        if (rfound) begin
          live_next = live - CNT_W'(1);
        end
        valid_next[eid[IDX_W-1:0]] = 1'b0;
        if (freed == END_W'(1) || END_W'(aoff) < freed) begin
          freed_next = END_W'(aoff);
        end
        res_rel_next = 1'b1;
        state_next   = S_END;
      end

      S_DF_ORD: begin
        if (idx >= live) begin
          freed_next  = END_W'(1);
          passes_next = passes + PASS_W'(1);
          state_next  = S_DF_NEXT;
        end else begin
          req.ord_raddr = idx[IDX_W-1:0];
          state_next    = S_DF_SLOT;
        end
      end
      S_DF_SLOT: begin
        req.slot_raddr = rsp.ord_q;
        ent_next       = rsp.ord_q;
        state_next     = S_DF_CMP;
      end
      S_DF_CMP: begin
        if (freed < END_W'(rsp.off_q)) begin
          req.off_we     = 1'b1;
          req.slot_waddr = ent;
          req.w_off      = freed[OFF_W-1:0];
          freed_next     = freed + END_W'(rsp.len_q);
          passes_next    = passes + PASS_W'(1);
          state_next     = S_DF_NEXT;
        end else begin
          if (freed == END_W'(rsp.off_q)) begin
            freed_next = freed + END_W'(rsp.len_q);
          end
          idx_next   = idx + CNT_W'(1);
          state_next = S_DF_ORD;
        end
      end
      S_DF_NEXT: begin
        if (!dfr && freed > END_W'(1) && 32'(passes) <= 32'(MAX_ENTRIES)) begin
          idx_next   = '0;
          state_next = S_DF_ORD;
        end else begin
          state_next = S_END;
        end
      end

      S_END: begin
        if (live == '0) begin
          used_next  = '0;
          state_next = S_OUT;
        end else begin
          state_next = S_END_ORD;
        end
      end
      S_END_ORD: begin
        req.ord_raddr = live[IDX_W-1:0] - IDX_W'(1);
        state_next    = S_END_SLOT;
      end
      S_END_SLOT: begin
        req.slot_raddr = rsp.ord_q;
        state_next     = S_END_CALC;
      end
      S_END_CALC: begin
        used_next  = END_W'(rsp.off_q) + END_W'(rsp.len_q);
        state_next = S_OUT;
      end

      S_OUT: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall      = (state != S_IDLE);
  assign out_valid     = (state == S_OUT);
  assign status        = res_status;
  assign result_entry  = res_entry;
  assign result_offset = res_off;
  assign was_released  = res_rel;
  assign used_chars    = used;
  assign free_chars    = END_W'(TOTAL_CHARS) - used;
  assign entry_count   = 7'(live);
  assign gap_pending   = (freed > END_W'(1));

endmodule
`default_nettype wire

@@ dv/tb.sv @@
// Testbench for the tile memory compacting allocator: directed and random requests against a predictor.
`timescale 1ns / 100ps
module tb;
  import tmca_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = OP_ACQUIRE;
  logic [31:0] tile_source_id = '0;
  logic        is_shared = 1'b0;
  logic [10:0] num_chars = '0;
  logic [5:0]  entry_id = '0;
  logic        deferred = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [5:0]  result_entry;
  logic [10:0] result_offset;
  logic        was_released;
  logic [11:0] used_chars;
  logic [11:0] free_chars;
  logic [6:0]  entry_count;
  logic        gap_pending;

  tile_memory_compacting_allocator DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  entry;
    logic [10:0] offset;
    logic        released;
    logic [11:0] used;
    logic [11:0] free;
    logic [6:0]  count;
    logic        gap;
  } alloc_word_t;

  alloc_word_t grant_q[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;

  // predictor state
  logic [31:0] m_key[MAX_ENTRIES];
  logic        m_shared[MAX_ENTRIES];
  int          m_off[MAX_ENTRIES];
  int          m_len[MAX_ENTRIES];
  int          m_use[MAX_ENTRIES];
  logic        m_valid[MAX_ENTRIES];
  int          m_order[MAX_ENTRIES];
  int          m_live;
  int          m_mark;

  function automatic int table_end();
    int last;
    if (m_live == 0) return 0;
    last = m_order[m_live-1];
    return m_off[last] + m_len[last];
  endfunction

  function automatic void table_clear();
    for (int i = 0; i < MAX_ENTRIES; i++) m_valid[i] = 1'b0;
    m_live = 0;
    m_mark = 1;
  endfunction

  function automatic void slide_once();
    int e;
    for (int i = 0; i < m_live; i++) begin
      e = m_order[i];
      if (m_mark < m_off[e]) begin
        m_off[e] = m_mark;
        m_mark += m_len[e];
        return;
      end else if (m_mark == m_off[e]) begin
        m_mark += m_len[e];
      end
    end
    m_mark = 1;
  endfunction

  function automatic alloc_word_t predict_alloc(logic [1:0] op, logic [31:0] key,
      logic sh, int n, int eid, logic dfr);
    alloc_word_t r;
    bit found;
    int e, off, slot, pos, passes, u;
    r = '0;
    found = 0;
    if (op == OP_ACQUIRE) begin
      if (sh) begin
        for (int i = 0; i < m_live && !found; i++) begin
          e = m_order[i];
          if (m_key[e] == key && m_shared[e]) begin
            if (m_use[e] < 255) m_use[e]++;
            r.entry = 6'(e);
            r.offset = 11'(m_off[e]);
            found = 1;
          end
        end
      end
      if (!found) begin
        off = (m_live == 0) ? 1 : table_end();
        if (n == 0 || n >= TOTAL_CHARS) r.status = ST_BAD_SIZE;
        else if (m_live >= MAX_ENTRIES) r.status = ST_FULL;
        else if (off + n >= TOTAL_CHARS) r.status = ST_NO_SPACE;
        else begin
          slot = 0;
          while (slot < MAX_ENTRIES && m_valid[slot]) slot++;
          m_valid[slot] = 1'b1;
          m_key[slot] = key;
          m_shared[slot] = sh;
          m_off[slot] = off;
          m_len[slot] = n;
          m_use[slot] = 1;
          m_order[m_live] = slot;
          m_live++;
          r.entry = 6'(slot);
          r.offset = 11'(off);
        end
      end
    end else if (op == OP_RELEASE) begin
      if (!m_valid[eid]) r.status = ST_NOTHING;
      else begin
        if (m_use[eid] > 0) m_use[eid]--;
        if (m_use[eid] == 0) begin
          off = m_off[eid];
          pos = 0;
          while (pos < m_live && m_order[pos] != eid) pos++;
          if (pos < m_live) begin
            for (int i = pos; i + 1 < m_live; i++) m_order[i] = m_order[i+1];
            m_live--;
          end
          m_valid[eid] = 1'b0;
          if (m_mark == 1 || off < m_mark) m_mark = off;
          r.released = 1'b1;
        end
      end
    end else if (op == OP_DEFRAG) begin
      if (m_mark > 1) begin
        passes = 0;
        do begin
          slide_once();
          passes++;
        end while (!dfr && m_mark > 1 && passes <= MAX_ENTRIES);
      end else r.status = ST_NOTHING;
    end else begin
      table_clear();
    end
    u = table_end();
    r.used = 12'(u);
    r.free = 12'(TOTAL_CHARS - u);
    r.count = 7'(m_live);
    r.gap = m_mark > 1;
    return r;
  endfunction

  task automatic send_word(logic [1:0] op, logic [31:0] key, logic sh,
      logic [10:0] n, logic [5:0] eid, logic dfr);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    tile_source_id <= key;
    is_shared <= sh;
    num_chars <= n;
    entry_id <= eid;
    deferred <= dfr;
    grant_q.push_back(predict_alloc(op, key, sh, n, eid, dfr));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  always @(posedge clk) begin
    alloc_word_t exp_w;
    if (!rst && out_valid && !out_stall) begin
      if (grant_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        exp_w = grant_q.pop_front();
        if (status !== exp_w.status) begin
          $error("status exp %0d got %0d", exp_w.status, status); errors++;
        end
        if (result_entry !== exp_w.entry) begin
          $error("result_entry exp %0d got %0d", exp_w.entry, result_entry); errors++;
        end
        if (result_offset !== exp_w.offset) begin
          $error("result_offset exp %0d got %0d", exp_w.offset, result_offset); errors++;
        end
        if (was_released !== exp_w.released) begin
          $error("was_released exp %0d got %0d", exp_w.released, was_released); errors++;
        end
        if (used_chars !== exp_w.used) begin
          $error("used_chars exp %0d got %0d", exp_w.used, used_chars); errors++;
        end
        if (free_chars !== exp_w.free) begin
          $error("free_chars exp %0d got %0d", exp_w.free, free_chars); errors++;
        end
        if (entry_count !== exp_w.count) begin
          $error("entry_count exp %0d got %0d", exp_w.count, entry_count); errors++;
        end
        if (gap_pending !== exp_w.gap) begin
          $error("gap_pending exp %0d got %0d", exp_w.gap, gap_pending); errors++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  task automatic drain();
    in_valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
  endtask

  function automatic int live_pick();
    int k;
    if (m_live == 0) return $urandom_range(63);
    k = $urandom_range(m_live - 1);
    return m_order[k];
  endfunction

  task automatic test_directed();
    send_word(OP_DEFRAG, '0, 0, 0, 0, 1);               // nothing to compact
    send_word(OP_RELEASE, '0, 0, 0, 0, 0);              // dead entry
    send_word(OP_ACQUIRE, 32'h0, 0, 0, 0, 0);           // zero size
    send_word(OP_ACQUIRE, 32'hFFFFFFFF, 1, 11'h7FF, 6'h3F, 1); // too large
    send_word(OP_ACQUIRE, 32'hFFFFFFFF, 1, 11'd10, 0, 0);
    send_word(OP_ACQUIRE, 32'hFFFFFFFF, 1, 11'h7FF, 0, 0);   // shared hit any size
    send_word(OP_ACQUIRE, 32'h12345678, 0, 11'd2036, 0, 0);  // fills to edge
    send_word(OP_ACQUIRE, 32'h1, 0, 11'd1, 0, 0);            // no space
    send_word(OP_RELEASE, '0, 0, 0, 6'd0, 0);                // count above zero
    send_word(OP_RELEASE, '0, 0, 0, 6'd0, 0);                // removed at offset 1
    send_word(OP_DEFRAG, '0, 0, 0, 0, 1);
    send_word(OP_CLEAR, '0, 0, 0, 0, 0);
    for (int i = 0; i < 6; i++) send_word(OP_ACQUIRE, i, 0, 11'd3, 0, 0);
    send_word(OP_RELEASE, '0, 0, 0, 6'd1, 0);
    send_word(OP_RELEASE, '0, 0, 0, 6'd3, 0);
    send_word(OP_DEFRAG, '0, 0, 0, 0, 1);
    send_word(OP_DEFRAG, '0, 0, 0, 0, 0);
    send_word(OP_CLEAR, '0, 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_saturation();
    send_word(OP_ACQUIRE, 32'hA5A5A5A5, 1, 11'd4, 0, 0);
    for (int i = 0; i < 260; i++) send_word(OP_ACQUIRE, 32'hA5A5A5A5, 1, 11'd4, 0, 0);
    for (int i = 0; i < 256; i++) send_word(OP_RELEASE, '0, 0, 0, 6'd0, 0);
    send_word(OP_CLEAR, '0, 0, 0, 0, 0);
  endtask

  task automatic test_full_table();
    for (int i = 0; i < 66; i++) send_word(OP_ACQUIRE, $urandom, 0, 11'd1, 0, 0);
    for (int i = 0; i < 20; i++)
      send_word(OP_RELEASE, '0, 0, 0, 6'($urandom_range(63)), 0);
    send_word(OP_DEFRAG, '0, 0, 0, 0, 0);
    drain();
    send_idle = 0;
    send_word(OP_CLEAR, '0, 0, 0, 0, 0);
  endtask

  task automatic test_random(int n_items);
    int r;
    logic [31:0] key;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(99);
      key = ($urandom_range(3) == 0) ? $urandom :
            32'($urandom_range(7)) ^ {1'($urandom_range(1)), 31'h0};
      if (r < 45)
        send_word(OP_ACQUIRE, key, 1'($urandom_range(1)),
                  ($urandom_range(19) == 0) ? 11'($urandom) : 11'($urandom_range(1, 60)),
                  6'($urandom), 1'($urandom_range(1)));
      else if (r < 80)
        send_word(OP_RELEASE, $urandom, 1'($urandom_range(1)), 11'($urandom),
                  ($urandom_range(9) == 0) ? 6'($urandom) : 6'(live_pick()),
                  1'($urandom_range(1)));
      else if (r < 97)
        send_word(OP_DEFRAG, $urandom, 1'($urandom_range(1)), 11'($urandom),
                  6'($urandom), 1'($urandom_range(1)));
      else
        send_word(OP_CLEAR, $urandom, 1'($urandom_range(1)), 11'($urandom),
                  6'($urandom), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    table_clear();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle = 35; recv_idle = 71;
    test_directed();
    test_saturation();
    test_random(340);
    drain();
    send_idle = 71; recv_idle = 35;
    test_full_table();
    test_random(340);
    drain();
    send_idle = 0; recv_idle = 0;
    test_random(340);
    drain();
    repeat (2000) @(posedge clk);
    if (errors == 0 && grant_q.size() == 0)
      $display("[tile_memory_compacting_allocator] OK");
    else
      $display("[tile_memory_compacting_allocator] ERROR");
    $finish;
  end

  initial begin
    #1s;
    $display("[tile_memory_compacting_allocator] ERROR");
    $finish;
  end
endmodule
